// ----- src/dsq_pkg.sv -----
// Shared types and constants for the deadline-sorted sleep queue.
// Used by dsq_cell and deadline_sorted_sleep_queue_core; no other dependencies.
package dsq_pkg;

  localparam int DEADLINE_W = 64;
  localparam int THREAD_W   = 6;
  localparam int MASK_W     = 64;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_MARK   = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic [DEADLINE_W-1:0]   deadline;
    logic [THREAD_W-1:0]     thread;
    logic [DEADLINE_W-1:0]   now;
    logic [MASK_W-1:0]       mask;
  } cell_cmd_t;

  // Contents of one queue slot, as handed between neighbors.
  typedef struct packed {
    logic                    valid;
    logic                    flag;
    logic [DEADLINE_W-1:0]   deadline;
    logic [THREAD_W-1:0]     thread;
  } cell_data_t;

endpackage

// ----- src/dsq_cell.sv -----
// One slot of the sorted sleep queue chain.
// Depends on dsq_pkg for the command and slot data types.
module dsq_cell #(
  parameter int THREAD_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  dsq_pkg::cell_cmd_t cmd,
  input  dsq_pkg::cell_data_t left_data,
  input  logic               left_gt,
  input  dsq_pkg::cell_data_t right_data,
  input  logic               shift_en,
  output dsq_pkg::cell_data_t cur,
  output logic               gt
);

  logic blocked;

  // The chain is sorted, so the cells holding later deadlines form a suffix.
  assign gt = cur.valid && (cur.deadline > cmd.deadline);

  assign blocked = ({1'b0, cur.thread} < (dsq_pkg::THREAD_W+1)'(THREAD_COUNT))
                   && cmd.mask[cur.thread];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
      cur.flag  <= 1'b0;
    end else begin
      case (cmd.op)
        dsq_pkg::CELL_INSERT: begin
          // Later entries move one slot right; the first of them, or else the first empty slot, takes the new one.
          if (gt || (!cur.valid && left_data.valid)) begin
            cur.valid <= 1'b1;
            cur.flag  <= 1'b0;
            if (left_gt) begin
              cur.deadline <= left_data.deadline;
              cur.thread   <= left_data.thread;
            end else begin
              cur.deadline <= cmd.deadline;
              cur.thread   <= cmd.thread;
            end
          end
        end
        dsq_pkg::CELL_MARK: begin
          cur.flag <= cur.valid && (cur.deadline <= cmd.now) && blocked;
        end
        dsq_pkg::CELL_REMOVE: begin
          if (shift_en) begin
            cur <= right_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/deadline_sorted_sleep_queue_core.sv -----
// Top level of the deadline-sorted sleep queue: a chain of dsq_cell slots and its sequencer.
// Depends on dsq_pkg and dsq_cell.
//
// The queue is a row of QUEUE_CAPACITY cells kept sorted by wake deadline, earliest at the
// head. An insert captures the transaction, then every cell compares the new deadline with
// its own in parallel and the later entries move one slot right, unless the last cell is
// full. A check captures the transaction, then every cell marks itself if it is expired and
// its thread is blocked, and then each cycle while the output register is free removes the
// first marked cell by moving the cells behind it one slot left while its thread leaves on
// the output, up to WAKE_BATCH threads. The single shift per cycle in the chain sets the
// check time. A new transaction is taken only when the previous one has put out its final
// result into the output register, which may still be waiting on m_tready.
module deadline_sorted_sleep_queue_core #(
  parameter int QUEUE_CAPACITY = 64,
  parameter int WAKE_BATCH     = 16,
  parameter int THREAD_COUNT   = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // thread_id [5:0], wake_deadline [69:6], check_time [133:70], blocked_mask [197:134]
  input  logic [199:0] s_tdata,
  // kind
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // woke_valid [0], woken_thread [6:1], status [7]
  output logic [7:0]   m_tdata,
  output logic         m_tlast
);

  localparam int CNT_W = $clog2(WAKE_BATCH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_MARK,
    ST_WALK
  } state_t;

  state_t                          state;
  logic [dsq_pkg::THREAD_W-1:0]    in_thread;
  logic [dsq_pkg::DEADLINE_W-1:0]  in_deadline;
  logic [dsq_pkg::DEADLINE_W-1:0]  in_now;
  logic [dsq_pkg::MASK_W-1:0]      in_mask;
  logic [CNT_W-1:0]                woken;

  dsq_pkg::cell_cmd_t              cmd;
  dsq_pkg::cell_data_t             data [QUEUE_CAPACITY];
  logic [QUEUE_CAPACITY-1:0]       gt;
  logic [QUEUE_CAPACITY-1:0]       flags;
  logic [QUEUE_CAPACITY-1:0]       shift_mask;
  logic [QUEUE_CAPACITY-1:0]       first_hit;
  logic [dsq_pkg::THREAD_W-1:0]    hit_thread;
  logic                            more_hits;
  logic                            any_hit;
  logic                            full;
  logic                            out_free;
  logic                            out_load;
  logic                            batch_ok;
  logic                            do_remove;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign full      = data[QUEUE_CAPACITY-1].valid;
  assign any_hit   = |flags;
  assign batch_ok  = woken < CNT_W'(WAKE_BATCH);
  assign do_remove = (state == ST_WALK) && out_free && any_hit && batch_ok;
  // Both the insert and the walk states put out a result whenever the output register is free.
  assign out_load  = out_free && ((state == ST_INSERT) || (state == ST_WALK));

  // Cells at and behind the first marked one shift left; x | -x covers exactly those bits.
  assign shift_mask = flags | (~flags + QUEUE_CAPACITY'(1));
  assign first_hit  = flags & (~flags + QUEUE_CAPACITY'(1));
  assign more_hits  = |(flags & ~first_hit);

  always_comb begin
    hit_thread = '0;
    for (int i = 0; i < QUEUE_CAPACITY; i++) begin
      hit_thread = hit_thread | (data[i].thread & {dsq_pkg::THREAD_W{first_hit[i]}});
    end
  end

  always_comb begin
    cmd.deadline = in_deadline;
    cmd.thread   = in_thread;
    cmd.now      = in_now;
    cmd.mask     = in_mask;
    cmd.op       = dsq_pkg::CELL_HOLD;
    case (state)
      ST_INSERT: begin
        if (out_free && !full) begin
          cmd.op = dsq_pkg::CELL_INSERT;
        end
      end
      ST_MARK: begin
        cmd.op = dsq_pkg::CELL_MARK;
      end
      ST_WALK: begin
        if (do_remove) begin
          cmd.op = dsq_pkg::CELL_REMOVE;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < QUEUE_CAPACITY; g++) begin : g_cell
    dsq_pkg::cell_data_t left_d;
    dsq_pkg::cell_data_t right_d;
    logic                left_g;

    assign flags[g] = data[g].flag;

    if (g == 0) begin : g_head
      assign left_d = '{valid: 1'b1, flag: 1'b0, deadline: '0, thread: '0};
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_d = data[g-1];
      assign left_g = gt[g-1];
    end

    if (g == QUEUE_CAPACITY - 1) begin : g_tail
      assign right_d = '{valid: 1'b0, flag: 1'b0, deadline: '0, thread: '0};
    end else begin : g_inner
      assign right_d = data[g+1];
    end

    dsq_cell #(
      .THREAD_COUNT(THREAD_COUNT)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left_data (left_d),
      .left_gt   (left_g),
      .right_data(right_d),
      .shift_en  (shift_mask[g]),
      .cur       (data[g]),
      .gt        (gt[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      woken    <= '0;
    end else begin
      m_tvalid <= out_load || (m_tvalid && !m_tready);
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            in_thread   <= s_tdata[5:0];
            in_deadline <= s_tdata[69:6];
            in_now      <= s_tdata[133:70];
            in_mask     <= s_tdata[197:134];
            woken       <= '0;
            state       <= s_tuser ? ST_MARK : ST_INSERT;
          end
        end
        ST_INSERT: begin
          if (out_free) begin
            m_tdata  <= {full, {dsq_pkg::THREAD_W{1'b0}}, 1'b0};
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_MARK: begin
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (do_remove) begin
            m_tdata  <= {1'b0, hit_thread, 1'b1};
            m_tlast  <= !more_hits || (woken == CNT_W'(WAKE_BATCH - 1));
            woken    <= woken + CNT_W'(1);
            if (!more_hits || (woken == CNT_W'(WAKE_BATCH - 1))) begin
              state <= ST_IDLE;
            end
          end else if (out_free) begin
            // Nothing to wake on this check.
            m_tdata  <= '0;
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
